/* design/bbr_pkg.sv */
// Package for the 3x3 box blur: sizes, register indexes and the result record.
// Used by every design file through scoped names; depends on nothing.
package bbr_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int DIM_W = 12;
  localparam int CH_W  = 8;
  localparam int NUM_CH = 3;
  localparam int PIX_W = NUM_CH * CH_W;
  localparam int WIN_N = 9;
  localparam int SUM_W = CH_W + 4;
  localparam int NUM_RES = 4;

  // floor(s / 9) == (s * RECIP_9) >> RECIP_SHIFT for every 9-pixel sum
  localparam int RECIP_SHIFT = 16;
  localparam int RECIP_W = 13;
  localparam logic [RECIP_W-1:0] RECIP_9 = RECIP_W'(((1 << RECIP_SHIFT) + 8) / 9);

  localparam int CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  // result slots: bit 0 (r-1,c-1), bit 1 (r-1,c), bit 2 (r,c-1), bit 3 (r,c)
  typedef struct packed {
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
    logic [NUM_RES-1:0] mask;
    logic [PIX_W-1:0]   a_val;
    logic [PIX_W-1:0]   b_val;
    logic [PIX_W-1:0]   c_val;
    logic [PIX_W-1:0]   d_val;
  } emit_item_t;

endpackage

/* design/bbr_emit.sv */
// Result stage of the box blur: holds one pixel's results and sends them one per transfer.
// Depends on bbr_pkg.
module bbr_emit (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     load,
  input  bbr_pkg::emit_item_t      item,
  output logic                     ready,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [bbr_pkg::ROW_W-1:0] out_row,
  output logic [bbr_pkg::COL_W-1:0] out_col,
  output logic [bbr_pkg::CH_W-1:0]  out_blue,
  output logic [bbr_pkg::CH_W-1:0]  out_green,
  output logic [bbr_pkg::CH_W-1:0]  out_red,
  output logic                     run_last,
  output logic                     frame_done
);

  bbr_pkg::emit_item_t held;
  logic                held_valid;
  logic [bbr_pkg::NUM_RES-1:0] mask_rest;
  logic                single;
  logic                xfer;
  logic [bbr_pkg::PIX_W-1:0] pix;

  assign mask_rest = held.mask & (held.mask - bbr_pkg::NUM_RES'(1));
  assign single    = (mask_rest == '0);
  assign xfer      = held_valid && !out_stall;
  assign ready     = !held_valid || (xfer && single);
  assign out_valid = held_valid;
  assign run_last  = single;

  always_comb begin
    out_row    = held.row;
    out_col    = held.col;
    pix        = held.d_val;
    frame_done = 1'b0;
    if (held.mask[0]) begin
      out_row = held.row - bbr_pkg::ROW_W'(1);
      out_col = held.col - bbr_pkg::COL_W'(1);
      pix     = held.a_val;
    end else if (held.mask[1]) begin
      out_row = held.row - bbr_pkg::ROW_W'(1);
      pix     = held.b_val;
    end else if (held.mask[2]) begin
      out_col = held.col - bbr_pkg::COL_W'(1);
      pix     = held.c_val;
    end else begin
      frame_done = 1'b1;
    end
    out_blue  = pix[0 +: bbr_pkg::CH_W];
    out_green = pix[bbr_pkg::CH_W +: bbr_pkg::CH_W];
    out_red   = pix[2*bbr_pkg::CH_W +: bbr_pkg::CH_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (load) begin
      held_valid <= 1'b1;
    end else if (xfer && single) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= item;
    end else if (xfer) begin
      held.mask <= mask_rest;
    end
  end

endmodule

/* design/box_blur_3x3_rgb.sv */
// Top level of the 3x3 box blur over a raster BGR pixel stream.
// Holds the line memory, window and sum pipeline; depends on bbr_pkg and bbr_emit.
//
//   port group   direction  handshake           payload
//   in           receive    in_valid/in_stall   in_blue, in_green, in_red
//   out          send       out_valid/out_stall out_row, out_col, out_blue/green/red,
//                                               run_last, frame_done
//   cfg          receive    cfg_write           cfg_index, cfg_data
//
// One pixel is taken per clock while in_stall is low; a pixel that yields k results
// holds the result stage for k transfers, so line ends and the last row cost extra
// cycles on the out side. A pixel and its line memory read register into stage 1,
// the window sum into stage 2, the divide-by-nine result into the result stage.
// Reset clears counters, window and pipeline valids; the line memory needs no clearing.
// A stall on out backs up through the pipeline to in_stall.
module box_blur_3x3_rgb (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [bbr_pkg::CH_W-1:0]  in_blue,
  input  logic [bbr_pkg::CH_W-1:0]  in_green,
  input  logic [bbr_pkg::CH_W-1:0]  in_red,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [bbr_pkg::ROW_W-1:0] out_row,
  output logic [bbr_pkg::COL_W-1:0] out_col,
  output logic [bbr_pkg::CH_W-1:0]  out_blue,
  output logic [bbr_pkg::CH_W-1:0]  out_green,
  output logic [bbr_pkg::CH_W-1:0]  out_red,
  output logic                      run_last,
  output logic                      frame_done,
  input  logic                      cfg_write,
  input  logic [bbr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bbr_pkg::DIM_W-1:0] cfg_data
);

  localparam int PW = bbr_pkg::PIX_W;
  localparam int CW = bbr_pkg::CH_W;

  logic [bbr_pkg::DIM_W-1:0] image_width;
  logic [bbr_pkg::DIM_W-1:0] image_height;
  logic [bbr_pkg::DIM_W-1:0] w_eff;
  logic [bbr_pkg::DIM_W-1:0] h_eff;

  logic [bbr_pkg::ROW_W-1:0] row;
  logic [bbr_pkg::COL_W-1:0] col;
  logic [bbr_pkg::ROW_W-1:0] row_next;
  logic [bbr_pkg::COL_W-1:0] col_next;
  logic [bbr_pkg::DIM_W-1:0] row_x;
  logic [bbr_pkg::DIM_W-1:0] col_x;
  logic last_col;
  logic last_row;
  logic in_xfer;
  logic [bbr_pkg::NUM_RES-1:0] in_mask;
  logic in_border;
  logic [PW-1:0] in_pix;

  logic [2*PW-1:0] line_mem [bbr_pkg::MAX_WIDTH];
  logic [2*PW-1:0] mem_q;
  logic [2*PW-1:0] fwd_data;
  logic            fwd_hit;
  logic [2*PW-1:0] rd_data;
  logic [PW-1:0]   up;
  logic [PW-1:0]   lo;

  logic                        s1_valid;
  logic [bbr_pkg::ROW_W-1:0]   s1_row;
  logic [bbr_pkg::COL_W-1:0]   s1_col;
  logic [PW-1:0]               s1_cur;
  logic [bbr_pkg::NUM_RES-1:0] s1_mask;
  logic                        s1_border;
  logic s1_ready;
  logic s1_adv;

  logic [PW-1:0] win [bbr_pkg::WIN_N];
  logic [bbr_pkg::SUM_W-1:0] sum [bbr_pkg::NUM_CH];

  logic                        s2_valid;
  logic [bbr_pkg::ROW_W-1:0]   s2_row;
  logic [bbr_pkg::COL_W-1:0]   s2_col;
  logic [bbr_pkg::NUM_RES-1:0] s2_mask;
  logic                        s2_border;
  logic [PW-1:0]               s2_center;
  logic [PW-1:0]               s2_lo;
  logic [PW-1:0]               s2_left;
  logic [PW-1:0]               s2_cur;
  logic [bbr_pkg::SUM_W-1:0]   s2_sum [bbr_pkg::NUM_CH];
  logic s2_ready;
  logic s2_empty;

  logic [bbr_pkg::SUM_W+bbr_pkg::RECIP_W-1:0] prod [bbr_pkg::NUM_CH];
  logic [PW-1:0] mean;
  logic e_ready;
  logic e_load;
  bbr_pkg::emit_item_t e_item;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= bbr_pkg::DIM_W'(640);
      image_height <= bbr_pkg::DIM_W'(480);
    end else if (cfg_write) begin
      unique case (bbr_pkg::cfg_reg_t'(cfg_index))
        bbr_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        bbr_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data;
      endcase
    end
  end

  always_comb begin
    if (image_width == '0) begin
      w_eff = bbr_pkg::DIM_W'(1);
    end else if (image_width > bbr_pkg::DIM_W'(bbr_pkg::MAX_WIDTH)) begin
      w_eff = bbr_pkg::DIM_W'(bbr_pkg::MAX_WIDTH);
    end else begin
      w_eff = image_width;
    end
    if (image_height == '0) begin
      h_eff = bbr_pkg::DIM_W'(1);
    end else if (image_height > bbr_pkg::DIM_W'(bbr_pkg::MAX_HEIGHT)) begin
      h_eff = bbr_pkg::DIM_W'(bbr_pkg::MAX_HEIGHT);
    end else begin
      h_eff = image_height;
    end
  end

  // position counters and result slots for the incoming pixel
  assign in_xfer  = in_valid && !in_stall;
  assign in_stall = !s1_ready;
  assign in_pix   = {in_red, in_green, in_blue};
  assign row_x    = bbr_pkg::DIM_W'(row);
  assign col_x    = bbr_pkg::DIM_W'(col);
  assign last_col = (col_x + bbr_pkg::DIM_W'(1)) >= w_eff;
  assign last_row = (row_x + bbr_pkg::DIM_W'(1)) >= h_eff;

  always_comb begin
    in_mask[0] = (row != '0) && (col != '0);
    in_mask[1] = (row != '0) && last_col;
    in_mask[2] = last_row && (col != '0);
    in_mask[3] = last_row && last_col;
    in_border  = (row_x == bbr_pkg::DIM_W'(1)) || (row_x >= h_eff)
              || (col_x == bbr_pkg::DIM_W'(1)) || (col_x >= w_eff);
    if (last_col) begin
      col_next = '0;
      row_next = last_row ? '0 : row + bbr_pkg::ROW_W'(1);
    end else begin
      col_next = col + bbr_pkg::COL_W'(1);
      row_next = row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0;
      col <= '0;
    end else if (in_xfer) begin
      row <= row_next;
      col <= col_next;
    end
  end

  // line memory: {lower row, upper row} per column, forward a same-column write
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      mem_q    <= line_mem[col];
      fwd_hit  <= s1_adv && (s1_col == col);
      fwd_data <= {s1_cur, lo};
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      line_mem[s1_col] <= {s1_cur, lo};
    end
  end

  assign rd_data = fwd_hit ? fwd_data : mem_q;
  assign up      = rd_data[PW-1:0];
  assign lo      = rd_data[2*PW-1:PW];

  // stage 1: pixel with its column from the line memory
  assign s1_ready = !s1_valid || s2_ready;
  assign s1_adv   = s1_valid && s2_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= in_xfer;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_row    <= row;
      s1_col    <= col;
      s1_cur    <= in_pix;
      s1_mask   <= in_mask;
      s1_border <= in_border;
    end
  end

  always_comb begin
    for (int ch = 0; ch < bbr_pkg::NUM_CH; ch++) begin
      sum[ch] = bbr_pkg::SUM_W'(win[1][ch*CW +: CW]) + bbr_pkg::SUM_W'(win[2][ch*CW +: CW])
              + bbr_pkg::SUM_W'(up[ch*CW +: CW])     + bbr_pkg::SUM_W'(win[4][ch*CW +: CW])
              + bbr_pkg::SUM_W'(win[5][ch*CW +: CW]) + bbr_pkg::SUM_W'(lo[ch*CW +: CW])
              + bbr_pkg::SUM_W'(win[7][ch*CW +: CW]) + bbr_pkg::SUM_W'(win[8][ch*CW +: CW])
              + bbr_pkg::SUM_W'(s1_cur[ch*CW +: CW]);
    end
  end

  // window: shift left, new column on the right
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < bbr_pkg::WIN_N; i++) begin
        win[i] <= '0;
      end
    end else if (s1_adv) begin
      for (int i = 0; i < 3; i++) begin
        win[i*3]     <= win[i*3+1];
        win[i*3+1]   <= win[i*3+2];
      end
      win[2] <= up;
      win[5] <= lo;
      win[8] <= s1_cur;
    end
  end

  // stage 2: channel sums and the copy candidates
  assign s2_empty = (s2_mask == '0);
  assign s2_ready = !s2_valid || e_ready || s2_empty;
  assign e_load   = s2_valid && e_ready && !s2_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_adv;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_row    <= s1_row;
      s2_col    <= s1_col;
      s2_mask   <= s1_mask;
      s2_border <= s1_border;
      s2_center <= win[5];
      s2_lo     <= lo;
      s2_left   <= win[8];
      s2_cur    <= s1_cur;
      for (int ch = 0; ch < bbr_pkg::NUM_CH; ch++) begin
        s2_sum[ch] <= sum[ch];
      end
    end
  end

  // divide by nine through the reciprocal
  always_comb begin
    for (int ch = 0; ch < bbr_pkg::NUM_CH; ch++) begin
      prod[ch] = (bbr_pkg::SUM_W+bbr_pkg::RECIP_W)'(s2_sum[ch])
               * (bbr_pkg::SUM_W+bbr_pkg::RECIP_W)'(bbr_pkg::RECIP_9);
      mean[ch*CW +: CW] = prod[ch][bbr_pkg::RECIP_SHIFT +: CW];
    end
  end

  always_comb begin
    e_item.row   = s2_row;
    e_item.col   = s2_col;
    e_item.mask  = s2_mask;
    e_item.a_val = s2_border ? s2_center : mean;
    e_item.b_val = s2_lo;
    e_item.c_val = s2_left;
    e_item.d_val = s2_cur;
  end

  bbr_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .load       (e_load),
    .item       (e_item),
    .ready      (e_ready),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_row    (out_row),
    .out_col    (out_col),
    .out_blue   (out_blue),
    .out_green  (out_green),
    .out_red    (out_red),
    .run_last   (run_last),
    .frame_done (frame_done)
  );

endmodule

/* design/bbr_checker.sv */
// Port-level checks for the box blur output channel, bound to the top level.
// Depends on bbr_pkg for field widths.
module bbr_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [bbr_pkg::ROW_W-1:0] out_row,
  input logic [bbr_pkg::COL_W-1:0] out_col,
  input logic [bbr_pkg::CH_W-1:0]  out_blue,
  input logic [bbr_pkg::CH_W-1:0]  out_green,
  input logic [bbr_pkg::CH_W-1:0]  out_red,
  input logic                      run_last,
  input logic                      frame_done
);

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_row) && $stable(out_col)
      && $stable(out_blue) && $stable(out_green) && $stable(out_red)
      && $stable(run_last) && $stable(frame_done))
    else $error("stalled result changed");

  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_done |-> run_last)
    else $error("frame end not last result of its pixel");

  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !run_last |=> out_valid)
    else $error("gap inside a pixel's results");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result after reset");

endmodule

bind box_blur_3x3_rgb bbr_checker u_bbr_checker (.*);

/* tb/sv/testbench.sv */
// Self-checking testbench for box_blur_3x3_rgb: random and directed raster frames,
// with a predictor of the 3x3 blur and the border copies. Depends on bbr_pkg and the block.
module testbench;

  localparam int HALF_PERIOD  = 5;
  localparam int RESET_CYCLES = 9;
  localparam int SETTLE       = 8;
  localparam int END_CYCLES   = 20;
  localparam int IDLE_LIMIT   = 2000;
  localparam int IDLE_PCT     = 18;
  localparam int CALM_START   = 150;
  localparam int CALM_END     = 450;
  localparam int HOLD_AT      = 200;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_ITEMS = 290;
  localparam int CLAMP_RUN    = 20;
  localparam int ROW_BITS     = bbr_pkg::ROW_W;
  localparam int COL_BITS     = bbr_pkg::COL_W;

  typedef struct packed {
    logic [bbr_pkg::CH_W-1:0] red;
    logic [bbr_pkg::CH_W-1:0] green;
    logic [bbr_pkg::CH_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [ROW_BITS-1:0] row;
    logic [COL_BITS-1:0] col;
    rgb_t                pix;
    logic                last;
    logic                done;
  } blur_result_t;

  typedef enum logic [1:0] {
    STEP_PIXEL,
    STEP_CONFIG,
    STEP_PAUSE
  } plan_kind_t;

  typedef struct {
    plan_kind_t                plan_kind;
    rgb_t                      pix;
    bbr_pkg::cfg_reg_t         reg_sel;
    logic [bbr_pkg::DIM_W-1:0] value;
  } plan_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [bbr_pkg::CH_W-1:0] in_blue = '0;
  logic [bbr_pkg::CH_W-1:0] in_green = '0;
  logic [bbr_pkg::CH_W-1:0] in_red = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [bbr_pkg::ROW_W-1:0] out_row;
  logic [bbr_pkg::COL_W-1:0] out_col;
  logic [bbr_pkg::CH_W-1:0] out_blue;
  logic [bbr_pkg::CH_W-1:0] out_green;
  logic [bbr_pkg::CH_W-1:0] out_red;
  logic run_last;
  logic frame_done;
  logic cfg_write = 1'b0;
  logic [bbr_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [bbr_pkg::DIM_W-1:0] cfg_data = '0;

  box_blur_3x3_rgb dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_blue    (in_blue),
    .in_green   (in_green),
    .in_red     (in_red),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_row    (out_row),
    .out_col    (out_col),
    .out_blue   (out_blue),
    .out_green  (out_green),
    .out_red    (out_red),
    .run_last   (run_last),
    .frame_done (frame_done),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  // predictor state
  rgb_t upper_line [bbr_pkg::MAX_WIDTH];
  rgb_t lower_line [bbr_pkg::MAX_WIDTH];
  rgb_t win [bbr_pkg::WIN_N] = '{default: '0};
  int unsigned row_cnt = 0;
  int unsigned col_cnt = 0;
  logic [bbr_pkg::DIM_W-1:0] width_reg = bbr_pkg::DIM_W'(640);
  logic [bbr_pkg::DIM_W-1:0] height_reg = bbr_pkg::DIM_W'(480);
  blur_result_t expected_blur [$];

  // stimulus plan and its own position tracking
  plan_item_t pixel_plan [$];
  logic [bbr_pkg::DIM_W-1:0] plan_w = bbr_pkg::DIM_W'(640);
  logic [bbr_pkg::DIM_W-1:0] plan_h = bbr_pkg::DIM_W'(480);
  int unsigned plan_row = 0;
  int unsigned plan_col = 0;

  logic in_taken = 1'b0;
  int cycle_count = 0;
  int quiet_cycles = 0;
  int idle_cycles = 0;
  int results_seen = 0;
  int mismatches = 0;
  int hold_left = 0;
  bit hold_used = 1'b0;

  function automatic int unsigned eff_dim(input logic [bbr_pkg::DIM_W-1:0] raw,
                                          input int unsigned maxv);
    if (raw == 0) return 1;
    if (raw > maxv) return maxv;
    return raw;
  endfunction

  function automatic rgb_t window_mean();
    int unsigned sb;
    int unsigned sg;
    int unsigned sr;
    rgb_t m;
    sb = 0;
    sg = 0;
    sr = 0;
    foreach (win[i]) begin
      sb += win[i].blue;
      sg += win[i].green;
      sr += win[i].red;
    end
    m.blue  = bbr_pkg::CH_W'(sb / bbr_pkg::WIN_N);
    m.green = bbr_pkg::CH_W'(sg / bbr_pkg::WIN_N);
    m.red   = bbr_pkg::CH_W'(sr / bbr_pkg::WIN_N);
    return m;
  endfunction

  function automatic void add_result(input int unsigned r, input int unsigned c, input rgb_t p,
                                     input logic done);
    blur_result_t e;
    e.row  = ROW_BITS'(r);
    e.col  = COL_BITS'(c);
    e.pix  = p;
    e.last = 1'b0;
    e.done = done;
    expected_blur.push_back(e);
  endfunction

  function automatic void blur_predict(input rgb_t cur);
    int unsigned w;
    int unsigned h;
    int unsigned r;
    int unsigned c;
    int n0;
    bit at_last_col;
    bit at_last_row;
    bit is_border;
    rgb_t up;
    rgb_t lo;
    blur_result_t tail;
    w = eff_dim(width_reg, bbr_pkg::MAX_WIDTH);
    h = eff_dim(height_reg, bbr_pkg::MAX_HEIGHT);
    r = row_cnt;
    c = col_cnt;
    up = upper_line[c];
    lo = lower_line[c];
    at_last_col = (c + 1 >= w);
    at_last_row = (r + 1 >= h);
    for (int i = 0; i < 3; i++) begin
      win[i*3]   = win[i*3+1];
      win[i*3+1] = win[i*3+2];
    end
    win[2] = up;
    win[5] = lo;
    win[8] = cur;
    upper_line[c] = lo;
    lower_line[c] = cur;
    n0 = expected_blur.size();
    if (r >= 1 && c >= 1) begin
      is_border = (r - 1 == 0) || (r >= h) || (c - 1 == 0) || (c >= w);
      add_result(r - 1, c - 1, is_border ? win[4] : window_mean(), 1'b0);
    end
    if (r >= 1 && at_last_col) add_result(r - 1, c, win[5], 1'b0);
    if (at_last_row && c >= 1) add_result(r, c - 1, win[7], 1'b0);
    if (at_last_row && at_last_col) add_result(r, c, cur, 1'b1);
    if (expected_blur.size() > n0) begin
      tail = expected_blur.pop_back();
      tail.last = 1'b1;
      expected_blur.push_back(tail);
    end
    if (at_last_col) begin
      col_cnt = 0;
      row_cnt = at_last_row ? 0 : r + 1;
    end else begin
      col_cnt = c + 1;
    end
  endfunction

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] seen);
    if (seen !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, seen);
    end
  endtask

  function automatic void plan_config(input bbr_pkg::cfg_reg_t sel,
                                      input logic [bbr_pkg::DIM_W-1:0] value);
    plan_item_t it;
    it.plan_kind = STEP_CONFIG;
    it.pix = '0;
    it.reg_sel = sel;
    it.value = value;
    pixel_plan.push_back(it);
    if (sel == bbr_pkg::REG_IMAGE_WIDTH) plan_w = value;
    else plan_h = value;
  endfunction

  function automatic void plan_pause();
    plan_item_t it;
    it.plan_kind = STEP_PAUSE;
    it.pix = '0;
    it.reg_sel = bbr_pkg::REG_IMAGE_WIDTH;
    it.value = '0;
    pixel_plan.push_back(it);
  endfunction

  function automatic void plan_pixel(input rgb_t p);
    plan_item_t it;
    int unsigned w;
    int unsigned h;
    w = eff_dim(plan_w, bbr_pkg::MAX_WIDTH);
    h = eff_dim(plan_h, bbr_pkg::MAX_HEIGHT);
    it.plan_kind = STEP_PIXEL;
    it.pix = p;
    it.reg_sel = bbr_pkg::REG_IMAGE_WIDTH;
    it.value = '0;
    pixel_plan.push_back(it);
    if (plan_col + 1 >= w) begin
      plan_col = 0;
      plan_row = (plan_row + 1 >= h) ? 0 : plan_row + 1;
    end else begin
      plan_col++;
    end
  endfunction

  function automatic logic [bbr_pkg::CH_W-1:0] rand_channel();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return bbr_pkg::CH_W'($urandom);
    endcase
  endfunction

  function automatic rgb_t rand_pixel();
    rgb_t p;
    p.red   = rand_channel();
    p.green = rand_channel();
    p.blue  = rand_channel();
    return p;
  endfunction

  function automatic bit calm();
    return cycle_count >= CALM_START && cycle_count < CALM_END;
  endfunction

  // driver: feed pixels and register writes from the plan
  always @(negedge clk) begin
    plan_item_t head;
    logic nv;
    logic ncw;
    if (!rst) begin
      nv = in_valid;
      ncw = 1'b0;
      if (!(in_valid && !in_taken)) begin
        nv = 1'b0;
        if (pixel_plan.size() > 0) begin
          head = pixel_plan[0];
          case (head.plan_kind)
            STEP_PIXEL: begin
              if (calm() || $urandom_range(99) >= IDLE_PCT) begin
                in_blue  <= head.pix.blue;
                in_green <= head.pix.green;
                in_red   <= head.pix.red;
                nv = 1'b1;
                void'(pixel_plan.pop_front());
              end
            end
            STEP_CONFIG: begin
              if (quiet_cycles >= SETTLE) begin
                cfg_index <= head.reg_sel;
                cfg_data  <= head.value;
                ncw = 1'b1;
                void'(pixel_plan.pop_front());
              end
            end
            default: begin
              if (quiet_cycles >= SETTLE) void'(pixel_plan.pop_front());
            end
          endcase
        end
      end
      in_valid  <= nv;
      cfg_write <= ncw;
    end
  end

  // receiver: random stalls and one long hold-off
  always @(negedge clk) begin
    if (!rst) begin
      if (!hold_used && results_seen >= HOLD_AT) begin
        hold_used = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm() && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // monitor: check results, predict on each pixel transfer, track idle time
  always @(posedge clk) begin
    blur_result_t got;
    blur_result_t want;
    bit moved;
    if (!rst) begin
      cycle_count++;
      moved = 1'b0;
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        results_seen++;
        got.row = out_row;
        got.col = out_col;
        got.pix.blue = out_blue;
        got.pix.green = out_green;
        got.pix.red = out_red;
        got.last = run_last;
        got.done = frame_done;
        if (expected_blur.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result at row %0d col %0d", $time, got.row, got.col);
        end else begin
          want = expected_blur.pop_front();
          check_field("out_row", 16'(want.row), 16'(got.row));
          check_field("out_col", 16'(want.col), 16'(got.col));
          check_field("out_blue", 16'(want.pix.blue), 16'(got.pix.blue));
          check_field("out_green", 16'(want.pix.green), 16'(got.pix.green));
          check_field("out_red", 16'(want.pix.red), 16'(got.pix.red));
          check_field("run_last", 16'(want.last), 16'(got.last));
          check_field("frame_done", 16'(want.done), 16'(got.done));
        end
      end
      if (in_valid && !in_stall) begin
        moved = 1'b1;
        blur_predict('{red: in_red, green: in_green, blue: in_blue});
      end
      if (cfg_write) begin
        moved = 1'b1;
        if (cfg_index == bbr_pkg::REG_IMAGE_WIDTH) width_reg = cfg_data;
        else height_reg = cfg_data;
      end
      quiet_cycles = (expected_blur.size() == 0 && !(in_valid && !in_stall))
                   ? quiet_cycles + 1 : 0;
      idle_cycles = moved ? 0 : idle_cycles + 1;
    end
    in_taken <= in_valid && !in_stall;
  end

  initial begin
    int unsigned sent;
    int unsigned n;
    int unsigned twist_at;
    bit twist;
    rgb_t p;

    // directed: saturated and alternating 3x3 frames, clamped and single-row sizes
    plan_config(bbr_pkg::REG_IMAGE_WIDTH, bbr_pkg::DIM_W'(3));
    plan_config(bbr_pkg::REG_IMAGE_HEIGHT, bbr_pkg::DIM_W'(3));
    repeat (9) plan_pixel('{red: '1, green: '1, blue: '1});
    plan_pause();
    for (int i = 0; i < 9; i++) begin
      p.red   = (i % 2) ? '1 : '0;
      p.green = (i % 3 == 0) ? '1 : '0;
      p.blue  = bbr_pkg::CH_W'(i * 28);
      plan_pixel(p);
    end
    plan_config(bbr_pkg::REG_IMAGE_WIDTH, '0);
    plan_config(bbr_pkg::REG_IMAGE_HEIGHT, '0);
    plan_pixel(rand_pixel());
    plan_config(bbr_pkg::REG_IMAGE_HEIGHT, bbr_pkg::DIM_W'(3));
    repeat (3) plan_pixel(rand_pixel());
    plan_config(bbr_pkg::REG_IMAGE_WIDTH, bbr_pkg::DIM_W'(4));
    plan_config(bbr_pkg::REG_IMAGE_HEIGHT, bbr_pkg::DIM_W'(1));
    repeat (4) plan_pixel(rand_pixel());

    // largest sizes: start a full-width row and a full-height column, then shrink mid-frame
    plan_config(bbr_pkg::REG_IMAGE_WIDTH, '1);
    plan_config(bbr_pkg::REG_IMAGE_HEIGHT, bbr_pkg::DIM_W'(1));
    repeat (CLAMP_RUN) plan_pixel(rand_pixel());
    plan_config(bbr_pkg::REG_IMAGE_WIDTH, bbr_pkg::DIM_W'(3));
    plan_pixel(rand_pixel());
    plan_config(bbr_pkg::REG_IMAGE_WIDTH, bbr_pkg::DIM_W'(1));
    plan_config(bbr_pkg::REG_IMAGE_HEIGHT, '1);
    repeat (CLAMP_RUN) plan_pixel(rand_pixel());
    plan_config(bbr_pkg::REG_IMAGE_HEIGHT, bbr_pkg::DIM_W'(3));
    plan_pixel(rand_pixel());

    // random frames, some with a size change or a pause in the middle
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent == 0 || $urandom_range(2) != 0) begin
        plan_config(bbr_pkg::REG_IMAGE_WIDTH, bbr_pkg::DIM_W'($urandom_range(1, 12)));
        plan_config(bbr_pkg::REG_IMAGE_HEIGHT, bbr_pkg::DIM_W'($urandom_range(1, 9)));
      end
      twist = ($urandom_range(4) == 0);
      twist_at = $urandom_range(1, eff_dim(plan_w, bbr_pkg::MAX_WIDTH)
                                   * eff_dim(plan_h, bbr_pkg::MAX_HEIGHT));
      n = 0;
      do begin
        plan_pixel(rand_pixel());
        n++;
        sent++;
        if (twist && n == twist_at) begin
          case ($urandom_range(2))
            0: plan_config(bbr_pkg::REG_IMAGE_WIDTH,
                           bbr_pkg::DIM_W'($urandom_range(1,
                                           eff_dim(plan_w, bbr_pkg::MAX_WIDTH))));
            1: plan_config(bbr_pkg::REG_IMAGE_HEIGHT, bbr_pkg::DIM_W'($urandom_range(1, 10)));
            default: plan_pause();
          endcase
        end
      end while (plan_row != 0 || plan_col != 0);
    end

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    @(negedge clk);
    while ((pixel_plan.size() > 0 || in_valid || expected_blur.size() > 0)
           && idle_cycles < IDLE_LIMIT)
      @(negedge clk);
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("box_blur_3x3_rgb regression: fail");
    end else begin
      repeat (END_CYCLES) @(negedge clk);
      if (mismatches == 0) begin
        $display("box_blur_3x3_rgb regression: pass");
      end else begin
        $display("box_blur_3x3_rgb regression: fail");
      end
    end
    $finish;
  end

endmodule

/* files.f */
design/bbr_pkg.sv
design/bbr_emit.sv
design/box_blur_3x3_rgb.sv
design/bbr_checker.sv
tb/sv/testbench.sv
